/* design/pwmfd_pkg.sv */
`timescale 1ns / 1ps

package pwmfd_pkg;

  // Field widths of the channels
  localparam int TIME_W   = 16;
  localparam int TICK_W   = 24;
  localparam int FREQ_W   = 16;
  localparam int DUTY_W   = 14;
  localparam int STATUS_W = 2;

  // Default capture counter width
  localparam int COUNTER_BITS_DEF = 16;

  // Depth of the queue between capture front and divider back
  localparam int QUEUE_DEPTH = 2;

  // Reset value of the tick rate register
  localparam logic [TICK_W-1:0] TICK_RATE_RESET = 24'd1000000;

  // Saturation limits; duty full scale is also the duty multiplier
  localparam logic [FREQ_W-1:0] FREQ_MAX  = 16'hFFFF;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd10000;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_PERIOD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FREQ_SAT    = 2'd2;

endpackage

/* design/pwmfd_if.sv */
`timescale 1ns / 1ps

// Capture event channel
interface pwmfd_in_if;
  logic                          valid;
  logic                          ready;
  logic [pwmfd_pkg::TIME_W-1:0]  rise_time;
  logic [pwmfd_pkg::TIME_W-1:0]  fall_time;

  modport source (output valid, output rise_time, output fall_time, input ready);
  modport sink   (input valid, input rise_time, input fall_time, output ready);
endinterface

// Measurement result channel
interface pwmfd_out_if;
  logic                            valid;
  logic                            ready;
  logic [pwmfd_pkg::FREQ_W-1:0]    frequency_hz;
  logic [pwmfd_pkg::DUTY_W-1:0]    duty_hundredths;
  logic [pwmfd_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output frequency_hz, output duty_hundredths,
                  output status, input ready);
  modport sink   (input valid, input frequency_hz, input duty_hundredths,
                  input status, output ready);
endinterface

// Tick rate register write channel
interface pwmfd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pwmfd_pkg::TICK_W-1:0]  tick_rate_hz;

  modport source (output valid, output tick_rate_hz, input ready);
  modport sink   (input valid, input tick_rate_hz, output ready);
endinterface

/* design/pwmfd_queue.sv */
`timescale 1ns / 1ps

module pwmfd_queue #(
  parameter int DataW = 8,
  parameter int Depth = pwmfd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [DataW-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [DataW-1:0] pop_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r;
  logic [PtrW-1:0]  rd_ptr_r;
  logic [CntW-1:0]  count_r;

  assign full      = (count_r == CntW'(Depth));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* design/pwmfd_front.sv */
`timescale 1ns / 1ps

module pwmfd_front #(
  parameter int  CounterBits = pwmfd_pkg::COUNTER_BITS_DEF,
  localparam int HighW       = CounterBits + pwmfd_pkg::DUTY_W,
  localparam int EntryW      = 1 + HighW + CounterBits
) (
  input  logic              clk,
  input  logic              rst_n,
  pwmfd_in_if.sink          in_ch,
  input  logic              q_full,
  output logic              q_push,
  output logic [EntryW-1:0] q_data
);

  logic                   armed_r;
  logic [CounterBits-1:0] start_r;
  logic                   accept;
  logic [CounterBits-1:0] rise_m;
  logic [CounterBits-1:0] fall_m;
  logic [CounterBits-1:0] period;
  logic [CounterBits-1:0] high;
  logic [HighW-1:0]       high_scaled;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Mask timestamps to the counter width and take wrapped differences
  assign rise_m      = CounterBits'(in_ch.rise_time);
  assign fall_m      = CounterBits'(in_ch.fall_time);
  assign period      = rise_m - start_r;
  assign high        = fall_m - start_r;
  assign high_scaled = HighW'(high) * HighW'(pwmfd_pkg::DUTY_FULL);

  // Queue a measurement on the closing edge of a period
  assign q_push = accept && armed_r;
  assign q_data = {(period == '0), high_scaled, period};

  // Hold the period start and toggle armed on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      start_r <= '0;
    end else if (accept) begin
      armed_r <= !armed_r;
      if (!armed_r) begin
        start_r <= rise_m;
      end
    end
  end

endmodule

/* design/pwmfd_back.sv */
`timescale 1ns / 1ps

module pwmfd_back #(
  parameter int  CounterBits = pwmfd_pkg::COUNTER_BITS_DEF,
  localparam int HighW       = CounterBits + pwmfd_pkg::DUTY_W,
  localparam int EntryW      = 1 + HighW + CounterBits
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  logic [EntryW-1:0] q_data,
  output logic              q_pop,
  pwmfd_cfg_if.sink         cfg_ch,
  pwmfd_out_if.source       out_ch
);

  localparam int DivW = (pwmfd_pkg::TICK_W > HighW) ? pwmfd_pkg::TICK_W : HighW;
  localparam int CntW = $clog2(DivW);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PACK,
    S_OUT
  } state_t;

  state_t                            state_r;
  logic [pwmfd_pkg::TICK_W-1:0]      tick_r;
  logic [CounterBits-1:0]            div_r;
  logic [DivW-1:0]                   fa_r;
  logic [CounterBits-1:0]            fr_r;
  logic [DivW-1:0]                   da_r;
  logic [CounterBits-1:0]            dr_r;
  logic [CntW-1:0]                   cnt_r;
  logic [pwmfd_pkg::FREQ_W-1:0]      freq_r;
  logic [pwmfd_pkg::DUTY_W-1:0]      duty_r;
  logic [pwmfd_pkg::STATUS_W-1:0]    status_r;

  logic                              e_zero;
  logic [HighW-1:0]                  e_high;
  logic [CounterBits-1:0]            e_period;
  logic [CounterBits:0]              fsh;
  logic [CounterBits:0]              dsh;
  logic [CounterBits:0]              fdiff;
  logic [CounterBits:0]              ddiff;
  logic                              fge;
  logic                              dge;
  logic [DivW-1:0]                   fa_nxt;
  logic [CounterBits-1:0]            fr_nxt;
  logic [DivW-1:0]                   da_nxt;
  logic [CounterBits-1:0]            dr_nxt;

  assign {e_zero, e_high, e_period} = q_data;

  assign q_pop        = (state_r == S_IDLE) && q_valid;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid           = (state_r == S_OUT);
  assign out_ch.frequency_hz    = freq_r;
  assign out_ch.duty_hundredths = duty_r;
  assign out_ch.status          = status_r;

  // One restoring division step per cycle on both lanes
  always_comb begin
    fsh    = {fr_r, fa_r[DivW-1]};
    dsh    = {dr_r, da_r[DivW-1]};
    fdiff  = fsh - {1'b0, div_r};
    ddiff  = dsh - {1'b0, div_r};
    fge    = (fsh >= {1'b0, div_r});
    dge    = (dsh >= {1'b0, div_r});
    fr_nxt = fge ? fdiff[CounterBits-1:0] : fsh[CounterBits-1:0];
    dr_nxt = dge ? ddiff[CounterBits-1:0] : dsh[CounterBits-1:0];
    fa_nxt = {fa_r[DivW-2:0], fge};
    da_nxt = {da_r[DivW-2:0], dge};
  end

  // Hold tick rate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= pwmfd_pkg::TICK_RATE_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      tick_r <= cfg_ch.tick_rate_hz;
    end
  end

  // Sequence: load, divide, saturate, present result; a zero period skips to the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (e_zero) begin
              freq_r   <= '0;
              duty_r   <= '0;
              status_r <= pwmfd_pkg::STATUS_ZERO_PERIOD;
              state_r  <= S_OUT;
            end else begin
              div_r   <= e_period;
              fa_r    <= DivW'(tick_r);
              da_r    <= DivW'(e_high);
              fr_r    <= '0;
              dr_r    <= '0;
              cnt_r   <= '0;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          fa_r  <= fa_nxt;
          fr_r  <= fr_nxt;
          da_r  <= da_nxt;
          dr_r  <= dr_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CntW'(DivW - 1)) begin
            state_r <= S_PACK;
          end
        end
        S_PACK: begin
          if (fa_r > DivW'(pwmfd_pkg::FREQ_MAX)) begin
            freq_r   <= pwmfd_pkg::FREQ_MAX;
            status_r <= pwmfd_pkg::STATUS_FREQ_SAT;
          end else begin
            freq_r   <= fa_r[pwmfd_pkg::FREQ_W-1:0];
            status_r <= pwmfd_pkg::STATUS_OK;
          end
          if (da_r > DivW'(pwmfd_pkg::DUTY_FULL)) begin
            duty_r <= pwmfd_pkg::DUTY_FULL;
          end else begin
            duty_r <= da_r[pwmfd_pkg::DUTY_W-1:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/pwm_input_frequency_duty_top.sv */
`timescale 1ns / 1ps
// Flow: an armed beat is queued, then the sequencer loads it, divides, saturates and
//   presents the result; a zero period goes from the load straight to the result.
// Back-pressure: the one bit per cycle divider takes a new queue entry only after the
//   last result is accepted; a two-entry queue lets capture beats arrive while it runs.
// Reset: synchronous active-low rst_n disarms, clears the period start, queue and
//   sequencer, and loads the tick rate with 1000000.

module pwm_input_frequency_duty_top #(
  parameter int CounterBits = pwmfd_pkg::COUNTER_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  pwmfd_in_if.sink     in_ch,
  pwmfd_out_if.source  out_ch,
  pwmfd_cfg_if.sink    cfg_ch
);

  localparam int HighW  = CounterBits + pwmfd_pkg::DUTY_W;
  localparam int EntryW = 1 + HighW + CounterBits;

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  logic [EntryW-1:0] q_wdata;
  logic [EntryW-1:0] q_rdata;

  // Capture front: arm and take period/high differences
  pwmfd_front #(.CounterBits(CounterBits)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // Decouple front and divider
  pwmfd_queue #(.DataW(EntryW), .Depth(pwmfd_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_rdata)
  );

  // Divider back: frequency and duty
  pwmfd_back #(.CounterBits(CounterBits)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");

  // A zero period reports zero frequency and duty
  a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == pwmfd_pkg::STATUS_ZERO_PERIOD) |->
      (out_ch.frequency_hz == '0) && (out_ch.duty_hundredths == '0))
    else $error("zero period result not cleared");

  // Saturated frequency status carries the full-scale frequency
  a_freq_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == pwmfd_pkg::STATUS_FREQ_SAT) |->
      (out_ch.frequency_hz == pwmfd_pkg::FREQ_MAX))
    else $error("saturated status without full-scale frequency");

  // Duty never exceeds full scale
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.duty_hundredths <= pwmfd_pkg::DUTY_FULL))
    else $error("duty above full scale");
`endif

endmodule
